// ----- rtl/mlsp_pkg.sv -----
// ============================================================================
// mlsp_pkg
// shared constants, codes and types of the multi linked stack pool
// ============================================================================
package mlsp_pkg;

    // default sizes
    localparam int NUM_STACKS_DEF = 5;
    localparam int POOL_NODES_DEF = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths
    localparam int MODE_W   = 2;
    localparam int SEL_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DISP = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PUSH_FREE,
        ST_POP_RD,
        ST_DISP_RD
    } state_t;

    // node memory port controls
    typedef struct packed {
        logic rd_en;
        logic val_we;
        logic link_we;
    } mem_ctl_t;

endpackage

// ----- rtl/mlsp_chan_if.sv -----
// ============================================================================
// mlsp channel interfaces
// valid/ready channels for operation beats and result beats
// ============================================================================
interface mlsp_in_if;
    import mlsp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [SEL_W-1:0]          stack_sel;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output mode, output stack_sel, output value, input ready);
    modport sink   (input valid, input mode, input stack_sel, input value, output ready);
endinterface

interface mlsp_out_if;
    import mlsp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic                      has_value;
    logic signed [VALUE_W-1:0] elem_value;
    logic                      last;

    modport source (output valid, output status, output has_value, output elem_value,
                    output last, input ready);
    modport sink   (input valid, input status, input has_value, input elem_value,
                    input last, output ready);
endinterface

// ----- rtl/mlsp_node_mem.sv -----
// ============================================================================
// mlsp_node_mem
// node pool storage: value and link words, one write and one read port
// ============================================================================
module mlsp_node_mem #(
    parameter int  POOL_NODES = mlsp_pkg::POOL_NODES_DEF,
    parameter int  DATA_WIDTH = mlsp_pkg::DATA_WIDTH_DEF,
    localparam int ADDR_W     = $clog2(POOL_NODES),
    localparam int PTR_W      = $clog2(POOL_NODES + 1)
) (
    input  logic                  clk,
    input  mlsp_pkg::mem_ctl_t    ctl,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_value,
    input  logic [PTR_W-1:0]      wr_link,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0] rd_value,
    output logic [PTR_W-1:0]      rd_link
);
    import mlsp_pkg::*;

    logic [DATA_WIDTH-1:0] value_mem [POOL_NODES];
    logic [PTR_W-1:0]      link_mem  [POOL_NODES];

    always_ff @(posedge clk)
    begin
        if (ctl.val_we)
        begin
            value_mem[wr_addr] <= wr_value;
        end
        if (ctl.link_we)
        begin
            link_mem[wr_addr] <= wr_link;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_value <= value_mem[rd_addr];
            rd_link  <= link_mem[rd_addr];
        end
    end

endmodule

// ----- rtl/multi_linked_stack_pool_top.sv -----
// ============================================================================
// multi_linked_stack_pool_top
// several linked stacks sharing one node pool with a free list
// ============================================================================
// sequence: a push of a never-used node is written from EXEC, a push from the
//   free list reads the free head's link in EXEC and writes in PUSH_FREE, a pop
//   reads in EXEC and answers in POP_RD, display reads in EXEC and then gives one beat per cycle in DISP_RD while
//   the receiver takes beats, one node memory read per element; one operation at a time
// reset: asynchronous active low, all stacks empty, free list empty, no node used
// ============================================================================
module multi_linked_stack_pool_top #(
    parameter int NUM_STACKS = mlsp_pkg::NUM_STACKS_DEF,
    parameter int POOL_NODES = mlsp_pkg::POOL_NODES_DEF,
    parameter int DATA_WIDTH = mlsp_pkg::DATA_WIDTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    mlsp_in_if.sink      in_ch,
    mlsp_out_if.source   out_ch
);
    import mlsp_pkg::*;

    localparam int ADDR_W = $clog2(POOL_NODES);
    localparam int PTR_W  = $clog2(POOL_NODES + 1);
    localparam int HIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [PTR_W-1:0] NULL_PTR  = PTR_W'(POOL_NODES);
    localparam logic [PTR_W-1:0] LAST_STEP = PTR_W'(POOL_NODES - 1);

    // sequencer
    state_t state_reg, state_next;

    // captured operation beat
    logic [MODE_W-1:0]         mode_reg;
    logic [SEL_W-1:0]          sel_reg;
    logic signed [VALUE_W-1:0] value_reg;

    // list heads and allocation state
    logic [PTR_W-1:0] heads_reg [NUM_STACKS];
    logic [PTR_W-1:0] free_reg, free_next;
    logic [PTR_W-1:0] fresh_reg, fresh_next;
    logic [PTR_W-1:0] steps_reg, steps_next;
    logic             head_we;
    logic [PTR_W-1:0] head_wdata;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_has_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic                out_last_reg;

    // result load controls
    logic                emit;
    logic [STATUS_W-1:0] e_status;
    logic                e_has;
    logic                e_last;

    // node memory side
    mem_ctl_t              mem_ctl;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_value;
    logic [PTR_W-1:0]      wr_link;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_WIDTH-1:0] rd_value;
    logic [PTR_W-1:0]      rd_link;

    // decode helpers
    logic              in_fire;
    logic              out_free;
    logic              sel_ok;
    logic [HIDX_W-1:0] head_idx;
    logic [PTR_W-1:0]  cur_head;
    logic              head_null;
    logic              free_avail;
    logic              fresh_avail;
    logic              disp_end;
    logic signed [63:0] in_wide;
    logic signed [63:0] rd_wide;

    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    // out-of-range stacks behave as always empty and never pushable
    assign sel_ok      = 32'(sel_reg) < NUM_STACKS;
    assign head_idx    = HIDX_W'(sel_reg);
    assign cur_head    = heads_reg[head_idx];
    assign head_null   = !(cur_head < NULL_PTR);
    assign free_avail  = free_reg < NULL_PTR;
    assign fresh_avail = fresh_reg < NULL_PTR;
    // display stops at the list end or after a full pool of steps
    assign disp_end    = !(rd_link < NULL_PTR) || (steps_reg == LAST_STEP);

    // pushed words keep their low bits, shown words sign-extend
    assign in_wide  = 64'(value_reg);
    assign rd_wide  = 64'(signed'(rd_value));
    assign wr_value = in_wide[DATA_WIDTH-1:0];

    mlsp_node_mem #(
        .POOL_NODES (POOL_NODES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_node_mem (
        .clk      (clk),
        .ctl      (mem_ctl),
        .wr_addr  (wr_addr),
        .wr_value (wr_value),
        .wr_link  (wr_link),
        .rd_addr  (rd_addr),
        .rd_value (rd_value),
        .rd_link  (rd_link)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                priority if (mode_reg == MODE_PUSH)
                begin
                    if (sel_ok && free_avail)
                    begin
                        state_next = ST_PUSH_FREE;
                    end
                    else if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (mode_reg == MODE_POP || mode_reg == MODE_DISP)
                begin
                    if (sel_ok && !head_null)
                    begin
                        state_next = (mode_reg == MODE_POP) ? ST_POP_RD : ST_DISP_RD;
                    end
                    else if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // unused mode: no beat, no change
                    state_next = ST_IDLE;
                end
            end
            ST_PUSH_FREE, ST_POP_RD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DISP_RD:
            begin
                if (out_free && disp_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
        emit        = 1'b0;
        e_status    = STATUS_OK;
        e_has       = 1'b0;
        e_last      = 1'b1;
        mem_ctl     = '0;
        wr_addr     = '0;
        wr_link     = cur_head;
        rd_addr     = cur_head[ADDR_W-1:0];
        head_we     = 1'b0;
        head_wdata  = cur_head;
        free_next   = free_reg;
        fresh_next  = fresh_reg;
        steps_next  = steps_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                priority if (mode_reg == MODE_PUSH)
                begin
                    if (sel_ok && free_avail)
                    begin
                        // fetch the link of the free list head
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = free_reg[ADDR_W-1:0];
                    end
                    else if (out_free)
                    begin
                        emit = 1'b1;
                        if (sel_ok && fresh_avail)
                        begin
                            mem_ctl.val_we  = 1'b1;
                            mem_ctl.link_we = 1'b1;
                            wr_addr         = fresh_reg[ADDR_W-1:0];
                            head_we         = 1'b1;
                            head_wdata      = fresh_reg;
                            fresh_next      = fresh_reg + PTR_W'(1);
                        end
                        else
                        begin
                            e_status = STATUS_FULL;
                        end
                    end
                end
                else if (mode_reg == MODE_POP || mode_reg == MODE_DISP)
                begin
                    if (sel_ok && !head_null)
                    begin
                        mem_ctl.rd_en = 1'b1;
                        steps_next    = '0;
                    end
                    else if (out_free)
                    begin
                        emit     = 1'b1;
                        e_status = STATUS_EMPTY;
                    end
                end
                else
                begin
                end
            end
            ST_PUSH_FREE:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    mem_ctl.val_we  = 1'b1;
                    mem_ctl.link_we = 1'b1;
                    wr_addr         = free_reg[ADDR_W-1:0];
                    head_we         = 1'b1;
                    head_wdata      = free_reg;
                    free_next       = rd_link;
                end
            end
            ST_POP_RD:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    e_has           = 1'b1;
                    mem_ctl.link_we = 1'b1;
                    wr_addr         = cur_head[ADDR_W-1:0];
                    wr_link         = free_reg;
                    head_we         = 1'b1;
                    head_wdata      = rd_link;
                    free_next       = cur_head;
                end
            end
            ST_DISP_RD:
            begin
                if (out_free)
                begin
                    emit   = 1'b1;
                    e_has  = 1'b1;
                    e_last = disp_end;
                    if (!disp_end)
                    begin
                        // follow the link while this element goes out
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = rd_link[ADDR_W-1:0];
                        steps_next    = steps_reg + PTR_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            free_reg  <= NULL_PTR;
            fresh_reg <= '0;
            steps_reg <= '0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                heads_reg[i] <= NULL_PTR;
            end
        end
        else
        begin
            state_reg <= state_next;
            free_reg  <= free_next;
            fresh_reg <= fresh_next;
            steps_reg <= steps_next;
            if (head_we)
            begin
                heads_reg[head_idx] <= head_wdata;
            end
        end
    end

    // captured operation beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg  <= in_ch.mode;
            sel_reg   <= in_ch.stack_sel;
            value_reg <= in_ch.value;
        end
    end

    // result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= e_status;
            out_has_reg    <= e_has;
            out_value_reg  <= e_has ? rd_wide[VALUE_W-1:0] : '0;
            out_last_reg   <= e_last;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.has_value  = out_has_reg;
    assign out_ch.elem_value = out_value_reg;
    assign out_ch.last       = out_last_reg;

endmodule

// ----- tb/sv/multi_linked_stack_pool_top_tb.sv -----
// ============================================================================
// multi_linked_stack_pool_top_tb
// self-checking bench for the shared-pool linked stacks: a behavioral model of
// the heads, links, free list and fresh counter predicts every result beat,
// and a checker compares the beats in order while both channels idle at random
// ============================================================================
module multi_linked_stack_pool_top_tb;
    import mlsp_pkg::*;

    localparam int NSTK      = NUM_STACKS_DEF;
    localparam int NNODE     = POOL_NODES_DEF;
    localparam int NULL_NODE = NNODE;           // end-of-list marker
    localparam int HOLD_CYCLES = 200;           // long receiver hold-off
    localparam int TAIL_CYCLES = 48;            // covers a full-depth display
    localparam int CYCLE_LIMIT = 1_000_000;

    // the one mode code that does nothing
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                has_value;
        logic [VALUE_W-1:0]  elem_value;
        logic                last;
    } result_beat_t;

    logic clk;
    logic rst_n;

    mlsp_in_if  in_ch ();
    mlsp_out_if out_ch ();

    multi_linked_stack_pool_top #(
        .NUM_STACKS (NSTK),
        .POOL_NODES (NNODE),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // model of the pool: node words, links, per-stack heads, free list
    logic [VALUE_W-1:0] pool_vals  [NNODE];
    int                 pool_links [NNODE];
    int                 top_of     [NSTK];
    int                 stack_depth[NSTK];
    int                 free_top;
    int                 fresh_next;
    int                 live_nodes;

    // beats still owed by the block, oldest first
    result_beat_t due_results[$];

    int  fail_count;
    int  beat_count;
    int  cycle_count;
    int  src_idle_pct;
    int  sink_idle_pct;
    bit  hold_req;
    int  hold_left;

    // 12-unit clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // free-running cycle count for the watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < 50)
            $display("mismatch @%0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    // works out the beats caused by one accepted operation and updates the model
    function automatic void predict_op(input logic [MODE_W-1:0] op,
                                       input logic [SEL_W-1:0]  sel,
                                       input logic [VALUE_W-1:0] val);
        int node;
        int nxt;
        int steps;
        bit in_range;
        in_range = (sel < NSTK);
        case (op)
            MODE_PUSH:
            begin
                // out-of-range stack can hold nothing, so it reads as pool full
                if (!in_range)
                    node = NULL_NODE;
                else if (free_top != NULL_NODE)
                begin
                    node     = free_top;
                    free_top = pool_links[node];
                end
                else if (fresh_next < NNODE)
                begin
                    node = fresh_next;
                    fresh_next++;
                end
                else
                    node = NULL_NODE;
                if (node == NULL_NODE)
                    due_results.push_back(result_beat_t'{STATUS_FULL, 1'b0, '0, 1'b1});
                else
                begin
                    pool_vals[node]  = val;
                    pool_links[node] = top_of[sel];
                    top_of[sel]      = node;
                    stack_depth[sel]++;
                    live_nodes++;
                    due_results.push_back(result_beat_t'{STATUS_OK, 1'b0, '0, 1'b1});
                end
            end
            MODE_POP:
            begin
                if (!in_range || top_of[sel] == NULL_NODE)
                    due_results.push_back(result_beat_t'{STATUS_EMPTY, 1'b0, '0, 1'b1});
                else
                begin
                    // unlink the top node and put it at the head of the free list
                    node             = top_of[sel];
                    top_of[sel]      = pool_links[node];
                    pool_links[node] = free_top;
                    free_top         = node;
                    stack_depth[sel]--;
                    live_nodes--;
                    due_results.push_back(result_beat_t'{STATUS_OK, 1'b1, pool_vals[node], 1'b1});
                end
            end
            MODE_DISP:
            begin
                if (!in_range || top_of[sel] == NULL_NODE)
                    due_results.push_back(result_beat_t'{STATUS_EMPTY, 1'b0, '0, 1'b1});
                else
                begin
                    // walk top to bottom, last flag on the bottom node
                    node = top_of[sel];
                    for (steps = 0; steps < NNODE && node != NULL_NODE; steps++)
                    begin
                        nxt = pool_links[node];
                        due_results.push_back(result_beat_t'{STATUS_OK, 1'b1, pool_vals[node],
                            (nxt == NULL_NODE || steps + 1 >= NNODE)});
                        node = nxt;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // element values lean on the sign boundaries now and then
    function automatic logic [VALUE_W-1:0] rand_element();
        case ($urandom_range(0, 19))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // offers one operation beat, optionally after a gap, and waits for accept;
    // called and returns at a rising edge so valid stays high back to back
    task automatic send_op(input logic [MODE_W-1:0] op,
                           input logic [SEL_W-1:0]  sel,
                           input logic [VALUE_W-1:0] val);
        int gap;
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= op;
        in_ch.stack_sel <= sel;
        in_ch.value     <= val;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_op(op, sel, val);
    endtask

    // receiver: random ready, or a long hold-off when asked for one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_req)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // checker: every accepted result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            result_beat_t want;
            beat_count++;
            if (due_results.size() == 0)
                report_mismatch($sformatf("beat %0d with nothing pending: st=%0d hv=%0b v=%h l=%0b",
                    beat_count, out_ch.status, out_ch.has_value, out_ch.elem_value,
                    out_ch.last));
            else
            begin
                want = due_results.pop_front();
                if (out_ch.status !== want.status || out_ch.has_value !== want.has_value ||
                    out_ch.elem_value !== want.elem_value || out_ch.last !== want.last)
                    report_mismatch($sformatf(
                        "beat %0d got st=%0d hv=%0b v=%h l=%0b want st=%0d hv=%0b v=%h l=%0b",
                        beat_count, out_ch.status, out_ch.has_value, out_ch.elem_value,
                        out_ch.last, want.status, want.has_value, want.elem_value, want.last));
            end
        end
    end

    // pops every stack down to empty
    task automatic drain_stacks();
        int s;
        for (s = 0; s < NSTK; s++)
            while (stack_depth[s] > 0)
                send_op(MODE_POP, SEL_W'(s), rand_element());
    endtask

    // empty stacks, out-of-range stacks and the unused mode
    task automatic test_empty_and_invalid();
        send_op(MODE_POP,    3'd0, 32'h0000_0000);
        send_op(MODE_DISP,   3'd4, 32'hffff_ffff);
        send_op(MODE_POP,    3'd5, 32'h1234_5678);
        send_op(MODE_DISP,   3'd7, 32'h0000_0000);
        send_op(MODE_PUSH,   3'd6, 32'h7fff_ffff);
        send_op(MODE_PUSH,   3'd7, 32'h8000_0000);
        send_op(MODE_UNUSED, 3'd0, 32'hdead_beef);
    endtask

    // lifo order, value extremes, display order and free-list reuse
    task automatic test_push_pop_order();
        send_op(MODE_PUSH, 3'd0, 32'h7fff_ffff);
        send_op(MODE_PUSH, 3'd0, 32'h8000_0000);
        send_op(MODE_PUSH, 3'd4, 32'hffff_ffff);
        send_op(MODE_PUSH, 3'd4, 32'h0000_0000);
        send_op(MODE_DISP, 3'd0, 32'h0000_0000);
        send_op(MODE_DISP, 3'd4, 32'h0000_0000);
        send_op(MODE_POP,  3'd0, 32'h0000_0000);
        // freed node comes back from the free list
        send_op(MODE_PUSH, 3'd1, 32'h0123_4567);
        send_op(MODE_POP,  3'd0, 32'h0000_0000);
        send_op(MODE_POP,  3'd0, 32'h0000_0000);
        send_op(MODE_POP,  3'd4, 32'h0000_0000);
        send_op(MODE_DISP, 3'd1, 32'h0000_0000);
        send_op(MODE_POP,  3'd1, 32'h0000_0000);
        send_op(MODE_POP,  3'd4, 32'h0000_0000);
    endtask

    // fills the whole pool into one stack while the receiver holds off,
    // then refused pushes, a full-depth display and free-list reuse
    task automatic test_pool_full_under_hold();
        drain_stacks();
        hold_req <= 1'b1;
        while (hold_left == 0)
            @(posedge clk);
        hold_req <= 1'b0;
        while (live_nodes < NNODE)
            send_op(MODE_PUSH, 3'd3, rand_element());
        send_op(MODE_PUSH, 3'd3, rand_element());
        send_op(MODE_PUSH, 3'd0, rand_element());
        send_op(MODE_DISP, 3'd3, 32'h0000_0000);
        send_op(MODE_POP,  3'd3, 32'h0000_0000);
        send_op(MODE_PUSH, 3'd2, rand_element());
        send_op(MODE_DISP, 3'd2, 32'h0000_0000);
        drain_stacks();
    endtask

    // random traffic: mostly tides of pushes and pops that swing the pool
    // between empty and full, with a tenth of noise
    task automatic test_random_traffic(input int n_ops, input int src_pct, input int sink_pct);
        int done;
        int roll;
        bit filling;
        logic [MODE_W-1:0] op;
        logic [SEL_W-1:0]  sel;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        done    = 0;
        filling = 1'b1;
        while (done < n_ops)
        begin
            if (live_nodes == NNODE && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (live_nodes == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                filling = !filling;
            roll = $urandom_range(0, 99);
            sel  = SEL_W'($urandom_range(0, NSTK - 1));
            if (roll < 10)
            begin
                op  = MODE_W'($urandom_range(0, 3));
                sel = SEL_W'($urandom_range(0, 7));
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    op = MODE_DISP;
                else if (roll < (filling ? 75 : 35))
                    op = MODE_PUSH;
                else
                    op = MODE_POP;
            end
            send_op(op, sel, rand_element());
            if (op != MODE_UNUSED)
                done++;
        end
    endtask

    initial
    begin
        int s;
        fail_count      = 0;
        beat_count      = 0;
        hold_req        = 1'b0;
        src_idle_pct    = 11;
        sink_idle_pct   = 68;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_PUSH;
        in_ch.stack_sel = '0;
        in_ch.value     = '0;
        out_ch.ready    = 1'b0;

        // model after reset: every stack and the free list empty
        for (s = 0; s < NSTK; s++)
        begin
            top_of[s]      = NULL_NODE;
            stack_depth[s] = 0;
        end
        free_top   = NULL_NODE;
        fresh_next = 0;
        live_nodes = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_invalid();
        test_push_pop_order();
        test_pool_full_under_hold();
        test_random_traffic(110, 11, 68);
        test_random_traffic(110, 68, 11);
        test_random_traffic(100, 0, 0);

        in_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        // let any stray beat show up
        repeat (TAIL_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d beats never arrived", due_results.size()));

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
